// File: rtl/bmpds_pkg.sv
// shared types and constants of the bmp decode and downscale block
package bmpds_pkg;

  localparam int CFG_W   = 13;
  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int COLOR_W = 16;

  localparam int HDR_BYTES  = 54;
  localparam int POS_OFFSET = 10;
  localparam int POS_WIDTH  = 18;
  localparam int POS_HEIGHT = 22;
  localparam int POS_DEPTH  = 28;

  localparam logic [7:0]       MAGIC_0      = 8'h42;
  localparam logic [7:0]       MAGIC_1      = 8'h4D;
  localparam logic [15:0]      DEPTH_24     = 16'd24;
  localparam logic [15:0]      DEPTH_32     = 16'd32;
  localparam logic [CFG_W-1:0] CANVAS_RESET = 13'd640;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_SHORT_HEADER = 3'd1,
    ERR_BAD_MAGIC    = 3'd2,
    ERR_BAD_DEPTH    = 3'd3,
    ERR_BAD_SIZE     = 3'd4,
    ERR_BAD_OFFSET   = 3'd5
  } error_code_e;

  typedef enum logic [0:0] {
    CFG_CANVAS_MAX_WIDTH  = 1'b0,
    CFG_CANVAS_MAX_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

// File: rtl/bmpds_if.sv
// stream channels: file bytes in, decode results out

interface bmpds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface bmpds_out_if;
  import bmpds_pkg::*;

  logic                valid;
  logic                ready;
  result_kind_e        result_kind;
  error_code_e         error_code;
  logic [ADDR_W-1:0]   pixel_address;
  logic [COLOR_W-1:0]  pixel_color;
  logic [DIM_W-1:0]    render_width;
  logic [DIM_W-1:0]    render_height;

  modport source (output valid, output result_kind, output error_code,
                  output pixel_address, output pixel_color, output render_width,
                  output render_height, input ready);
  modport sink (input valid, input result_kind, input error_code,
                input pixel_address, input pixel_color, input render_width,
                input render_height, output ready);
endinterface

// File: rtl/bmp_decode_downscale_rgb565_top.sv
// bmp byte stream parser with power-of-two downscale to rgb565 canvas words
//
// one file byte is taken per item on in_i, one item per clock when out_o
// drains; each byte gives at most one result, held in a single output
// register so a new byte is taken in the same cycle that a result leaves.
// the 54-byte header is parsed on the fly; on its last byte the magic,
// depth, size and offset checks and the downscale step search (one compare
// pair per candidate step, all side by side) run in that single cycle and
// a header or error item comes out. bytes up to the pixel offset are
// skipped, then rows are walked with pixel, byte-within-pixel and padding
// counters, so no division is needed. kept pixels come out as rgb565 with
// address = out_row * render_width + out_col; the row product is kept in a
// two-stage register pipe (row index, then product) that is always settled
// before the third byte of a pixel arrives. end_of_file returns the parser
// to the header state after its byte. canvas limits are sampled on the
// last header byte; write them only between files.
module bmp_decode_downscale_rgb565_top #(
  parameter int MAX_SOURCE_DIM_BITS = 16,
  parameter int CANVAS_DIM_LIMIT    = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  bmpds_pkg::cfg_reg_e         cfg_index_i,
  input  logic [bmpds_pkg::CFG_W-1:0] cfg_data_i,
  bmpds_in_if.sink                    in_i,
  bmpds_out_if.source                 out_o
);
  import bmpds_pkg::*;

  localparam int MB  = MAX_SOURCE_DIM_BITS;
  localparam int SW  = $clog2(MB + 1);
  localparam int LW  = CFG_W + 1;
  localparam int CW  = (MB > LW) ? MB : LW;
  localparam int PW  = MB + DIM_W;
  localparam int AXW = (PW > ADDR_W) ? PW : ADDR_W;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXELS = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_e;

  // control state
  phase_e           phase_q, phase_d;
  logic [31:0]      pos_q, pos_d;
  logic             magic_ok_q, magic_ok_d;
  logic [MB-1:0]    row_q, row_d;
  logic [MB-1:0]    px_q, px_d;
  logic [1:0]       part_q, part_d;
  logic             in_pad_q, in_pad_d;
  logic [1:0]       pad_q, pad_d;
  logic             out_valid_q, out_valid_d;
  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;

  // header fields and image geometry
  logic [31:0]      offset_q, offset_d;
  logic [31:0]      raw_w_q, raw_w_d;
  logic [31:0]      raw_h_q, raw_h_d;
  logic [15:0]      raw_d_q, raw_d_d;
  logic [MB-1:0]    width_q, width_d;
  logic [MB-1:0]    height_q, height_d;
  logic             bottom_up_q, bottom_up_d;
  logic             bpp4_q, bpp4_d;
  logic [SW-1:0]    step_q, step_d;
  logic [DIM_W-1:0] out_w_q, out_w_d;
  logic [DIM_W-1:0] out_h_q, out_h_d;
  logic [15:0]      held_q, held_d;

  // address pipe
  logic [MB-1:0]    dy_q;
  logic [PW-1:0]    prod_q;

  // result register
  result_kind_e       kind_q, kind_d;
  error_code_e        err_q, err_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [DIM_W-1:0]   rw_q, rw_d;
  logic [DIM_W-1:0]   rh_q, rh_d;

  logic             acc;
  logic [7:0]       b;
  logic [5:0]       hpos;
  logic [1:0]       off_sel, w_sel, h_sel;
  logic             d_sel;

  // header check terms
  logic             h_neg;
  logic [31:0]      h_abs;
  logic             depth_ok, size_bad, off_bad;
  error_code_e      hdr_err;
  logic [MB-1:0]    src_w, src_h;
  logic [LW-1:0]    lim, mw, mh;
  logic [MB-1:0]    w_ceil [MB+1];
  logic [MB-1:0]    h_ceil [MB+1];
  logic [SW-1:0]    step_sel;
  logic [MB-1:0]    ow_sel, oh_sel;

  // pixel walk terms
  logic [MB-1:0]    kmask;
  logic             row_keep, px_keep, part_last, data_last, row_end;
  logic [1:0]       pad_amt;
  logic [MB-1:0]    col;
  logic [AXW-1:0]   addr_full;

  assign acc        = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign b          = in_i.file_byte;
  assign hpos       = pos_q[5:0];
  assign off_sel    = 2'(hpos - 6'(POS_OFFSET));
  assign w_sel      = 2'(hpos - 6'(POS_WIDTH));
  assign h_sel      = 2'(hpos - 6'(POS_HEIGHT));
  assign d_sel      = 1'(hpos - 6'(POS_DEPTH));

  // ---- header checks, all from registered fields ----
  assign h_neg    = raw_h_q[31];
  assign h_abs    = h_neg ? (~raw_h_q + 32'd1) : raw_h_q;
  assign depth_ok = (raw_d_q == DEPTH_24) || (raw_d_q == DEPTH_32);
  assign size_bad = raw_w_q[31] || (raw_w_q == 32'd0) || (|raw_w_q[31:MB]) ||
                    (h_abs == 32'd0) || (|h_abs[31:MB]);
  assign off_bad  = offset_q < 32'(HDR_BYTES);
  assign src_w    = raw_w_q[MB-1:0];
  assign src_h    = h_abs[MB-1:0];

  always_comb begin
    if (!magic_ok_q)    hdr_err = ERR_BAD_MAGIC;
    else if (!depth_ok) hdr_err = ERR_BAD_DEPTH;
    else if (size_bad)  hdr_err = ERR_BAD_SIZE;
    else if (off_bad)   hdr_err = ERR_BAD_OFFSET;
    else                hdr_err = ERR_NONE;
  end

  // effective canvas limits: zero acts as one, clamp at the hard limit
  assign lim = LW'(CANVAS_DIM_LIMIT);
  assign mw  = (cfg_w_q == '0) ? LW'(1) : ((LW'(cfg_w_q) > lim) ? lim : LW'(cfg_w_q));
  assign mh  = (cfg_h_q == '0) ? LW'(1) : ((LW'(cfg_h_q) > lim) ? lim : LW'(cfg_h_q));

  // rounded-up size at every candidate step, then the smallest step that fits
  always_comb begin
    for (int s = 0; s <= MB; s++) begin
      w_ceil[s] = (src_w >> s) + MB'(|(src_w & ~({MB{1'b1}} << s)));
      h_ceil[s] = (src_h >> s) + MB'(|(src_h & ~({MB{1'b1}} << s)));
    end
    step_sel = SW'(MB);
    ow_sel   = w_ceil[MB];
    oh_sel   = h_ceil[MB];
    for (int s = MB; s >= 0; s--) begin
      if ((CW'(w_ceil[s]) <= CW'(mw)) && (CW'(h_ceil[s]) <= CW'(mh))) begin
        step_sel = SW'(s);
        ow_sel   = w_ceil[s];
        oh_sel   = h_ceil[s];
      end
    end
  end

  // ---- pixel walk ----
  assign kmask     = ~({MB{1'b1}} << step_q);
  assign row_keep  = (row_q & kmask) == '0;
  assign px_keep   = (px_q & kmask) == '0;
  assign part_last = bpp4_q ? (part_q == 2'd3) : (part_q == 2'd2);
  assign data_last = part_last && ((px_q + MB'(1)) == width_q);
  // 24-bit rows pad by width mod 4, 32-bit rows never pad
  assign pad_amt   = bpp4_q ? 2'd0 : width_q[1:0];
  assign col       = px_q >> step_q;
  assign addr_full = AXW'(prod_q) + AXW'(col);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    magic_ok_d  = magic_ok_q;
    row_d       = row_q;
    px_d        = px_q;
    part_d      = part_q;
    in_pad_d    = in_pad_q;
    pad_d       = pad_q;
    offset_d    = offset_q;
    raw_w_d     = raw_w_q;
    raw_h_d     = raw_h_q;
    raw_d_d     = raw_d_q;
    width_d     = width_q;
    height_d    = height_q;
    bottom_up_d = bottom_up_q;
    bpp4_d      = bpp4_q;
    step_d      = step_q;
    out_w_d     = out_w_q;
    out_h_d     = out_h_q;
    held_d      = held_q;
    row_end     = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    err_d       = err_q;
    addr_d      = addr_q;
    color_d     = color_q;
    rw_d        = rw_q;
    rh_d        = rh_q;

    if (acc) begin
      pos_d = pos_q + 32'd1;
      case (phase_q)
        PH_HEADER: begin
          if (hpos == 6'd0 && b != MAGIC_0) magic_ok_d = 1'b0;
          if (hpos == 6'd1 && b != MAGIC_1) magic_ok_d = 1'b0;
          if (hpos >= 6'(POS_OFFSET) && hpos <= 6'(POS_OFFSET + 3))
            offset_d[{off_sel, 3'b000} +: 8] = b;
          if (hpos >= 6'(POS_WIDTH) && hpos <= 6'(POS_WIDTH + 3))
            raw_w_d[{w_sel, 3'b000} +: 8] = b;
          if (hpos >= 6'(POS_HEIGHT) && hpos <= 6'(POS_HEIGHT + 3))
            raw_h_d[{h_sel, 3'b000} +: 8] = b;
          if (hpos >= 6'(POS_DEPTH) && hpos <= 6'(POS_DEPTH + 1))
            raw_d_d[{d_sel, 3'b000} +: 8] = b;

          if (hpos == 6'(HDR_BYTES - 1)) begin
            bottom_up_d = !h_neg;
            out_valid_d = 1'b1;
            addr_d      = '0;
            color_d     = '0;
            if (hdr_err != ERR_NONE) begin
              phase_d = PH_ERROR;
              kind_d  = KIND_ERROR;
              err_d   = hdr_err;
              rw_d    = '0;
              rh_d    = '0;
            end else begin
              phase_d  = (offset_q == 32'(HDR_BYTES)) ? PH_PIXELS : PH_SKIP;
              width_d  = src_w;
              height_d = src_h;
              bpp4_d   = raw_d_q == DEPTH_32;
              step_d   = step_sel;
              out_w_d  = DIM_W'(ow_sel);
              out_h_d  = DIM_W'(oh_sel);
              kind_d   = KIND_HEADER;
              err_d    = ERR_NONE;
              rw_d     = DIM_W'(ow_sel);
              rh_d     = DIM_W'(oh_sel);
            end
          end else if (in_i.end_of_file) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_ERROR;
            err_d       = ERR_SHORT_HEADER;
            addr_d      = '0;
            color_d     = '0;
            rw_d        = '0;
            rh_d        = '0;
          end
        end

        PH_SKIP: begin
          if (({1'b0, pos_q} + 33'd1) >= {1'b0, offset_q}) phase_d = PH_PIXELS;
        end

        PH_PIXELS: begin
          if (!in_pad_q) begin
            if (row_keep && px_keep) begin
              if (part_q == 2'd0) begin
                held_d[7:0] = b;
              end else if (part_q == 2'd1) begin
                held_d[15:8] = b;
              end else if (part_q == 2'd2) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_PIXEL;
                err_d       = ERR_NONE;
                addr_d      = addr_full[ADDR_W-1:0];
                color_d     = {b[7:3], held_q[15:10], held_q[7:3]};
                rw_d        = out_w_q;
                rh_d        = out_h_q;
              end
            end
            if (data_last) begin
              px_d   = '0;
              part_d = 2'd0;
              if (pad_amt == 2'd0) begin
                row_end = 1'b1;
              end else begin
                in_pad_d = 1'b1;
                pad_d    = pad_amt;
              end
            end else if (part_last) begin
              part_d = 2'd0;
              px_d   = px_q + MB'(1);
            end else begin
              part_d = part_q + 2'd1;
            end
          end else begin
            if (pad_q == 2'd1) row_end = 1'b1;
            else               pad_d   = pad_q - 2'd1;
          end
          if (row_end) begin
            in_pad_d = 1'b0;
            pad_d    = 2'd0;
            row_d    = row_q + MB'(1);
            if ((row_q + MB'(1)) == height_q) phase_d = PH_DONE;
          end
        end

        default: ;
      endcase

      // last byte of the file: back to header parsing
      if (in_i.end_of_file) begin
        phase_d    = PH_HEADER;
        pos_d      = '0;
        magic_ok_d = 1'b1;
        row_d      = '0;
        px_d       = '0;
        part_d     = 2'd0;
        in_pad_d   = 1'b0;
        pad_d      = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      magic_ok_q  <= 1'b1;
      row_q       <= '0;
      px_q        <= '0;
      part_q      <= 2'd0;
      in_pad_q    <= 1'b0;
      pad_q       <= 2'd0;
      out_valid_q <= 1'b0;
      cfg_w_q     <= CANVAS_RESET;
      cfg_h_q     <= CANVAS_RESET;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      magic_ok_q  <= magic_ok_d;
      row_q       <= row_d;
      px_q        <= px_d;
      part_q      <= part_d;
      in_pad_q    <= in_pad_d;
      pad_q       <= pad_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CANVAS_MAX_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_CANVAS_MAX_HEIGHT: cfg_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q    <= offset_d;
    raw_w_q     <= raw_w_d;
    raw_h_q     <= raw_h_d;
    raw_d_q     <= raw_d_d;
    width_q     <= width_d;
    height_q    <= height_d;
    bottom_up_q <= bottom_up_d;
    bpp4_q      <= bpp4_d;
    step_q      <= step_d;
    out_w_q     <= out_w_d;
    out_h_q     <= out_h_d;
    held_q      <= held_d;
    kind_q      <= kind_d;
    err_q       <= err_d;
    addr_q      <= addr_d;
    color_q     <= color_d;
    rw_q        <= rw_d;
    rh_q        <= rh_d;
    // output row index, flipped for bottom-up files, then its row base
    dy_q        <= bottom_up_q ? ((height_q - MB'(1) - row_q) >> step_q)
                               : (row_q >> step_q);
    prod_q      <= PW'(dy_q) * PW'(out_w_q);
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = kind_q;
  assign out_o.error_code    = err_q;
  assign out_o.pixel_address = addr_q;
  assign out_o.pixel_color   = color_q;
  assign out_o.render_width  = rw_q;
  assign out_o.render_height = rh_q;

`ifndef NO_ASSERTIONS
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.end_of_file |=> phase_q == PH_HEADER && pos_q == '0)
    else $error("parser not back in header state after end of file");

  a_header_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_HEADER |-> rw_q != '0 && rh_q != '0)
    else $error("header item with zero render size");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_ERROR |-> err_q != ERR_NONE && rw_q == '0 && rh_q == '0)
    else $error("error item without code or with render size");

  a_px_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PIXELS && !in_pad_q |-> px_q < width_q)
    else $error("pixel counter ran past the row width");
`endif

endmodule
